>>> rtl/orl_pkg.sv
package orl_pkg;

   // list geometry
   localparam int DEPTH = 16;
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   // word field widths
   localparam int OP_W  = 2;
   localparam int FLD_W = 32;
   localparam int REC_W = 4 * FLD_W;
   localparam int ST_W  = 2;
   localparam int POS_W = 4;
   localparam int REM_W = 5;
   localparam int OCC_W = 5;

   typedef enum logic [OP_W-1:0] {
      OP_FRONT  = 2'd0,
      OP_BACK   = 2'd1,
      OP_SEARCH = 2'd2,
      OP_DELETE = 2'd3
   } op_type;

   typedef enum logic [ST_W-1:0] {
      ST_DONE = 2'd0,
      ST_MISS = 2'd1,
      ST_FULL = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_WALK,
      S_FINISH
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic accept;
      logic walk;
      logic finish;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic need_walk;
      logic walk_done;
      logic out_free;
   } sts_type;

endpackage

>>> rtl/orl_ram.sv
module orl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/orl_ctrl.sv
module orl_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  orl_pkg::sts_type sts,
   output orl_pkg::cmd_type cmd
);

   import orl_pkg::*;

   state_type state_ff;
   state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = sts.need_walk ? S_WALK : S_FINISH;
            end
         end
         S_WALK: begin
            if (sts.walk_done) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (sts.out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      req_ready  = 1'b0;
      cmd.accept = 1'b0;
      cmd.walk   = 1'b0;
      cmd.finish = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
         end
         S_WALK: begin
            cmd.walk = 1'b1;
         end
         S_FINISH: begin
            cmd.finish = sts.out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // an accepted word that needs a walk is followed by a walk
   a_walk_after_accept: assert property (@(posedge clock) disable iff (reset)
      cmd.accept && sts.need_walk |=> cmd.walk)
      else $error("walk did not start after accept");

   // no new word is taken while a walk runs or a result is being committed
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(cmd.accept && (cmd.walk || cmd.finish)))
      else $error("accept overlaps walk or finish");

   // finish leaves the controller idle
   a_finish_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> req_ready)
      else $error("not idle after finish");

endmodule

>>> rtl/orl_dp.sv
module orl_dp (
   input  logic                             clock,
   input  logic                             reset,
   input  orl_pkg::cmd_type                 cmd,
   output orl_pkg::sts_type                 sts,
   input  logic [orl_pkg::OP_W-1:0]         req_operation,
   input  logic signed [orl_pkg::FLD_W-1:0] req_field_a,
   input  logic signed [orl_pkg::FLD_W-1:0] req_field_b,
   input  logic signed [orl_pkg::FLD_W-1:0] req_field_c,
   input  logic signed [orl_pkg::FLD_W-1:0] req_field_d,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [orl_pkg::ST_W-1:0]         rsp_status,
   output logic [orl_pkg::POS_W-1:0]        rsp_position,
   output logic [orl_pkg::REM_W-1:0]        rsp_removed,
   output logic [orl_pkg::OCC_W-1:0]        rsp_occupancy
);

   import orl_pkg::*;

   // control registers
   logic [CNT_W-1:0] count_ff, count_in;
   logic             data_vld_ff, data_vld_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // working registers
   op_type           op_ff, op_in;
   logic [REC_W-1:0] key_ff, key_in;
   logic [CNT_W-1:0] scan_ff, scan_in;
   logic [IDX_W-1:0] data_idx_ff, data_idx_in;
   logic [CNT_W-1:0] kept_ff, kept_in;
   logic [CNT_W-1:0] removed_ff, removed_in;
   logic             found_ff, found_in;
   logic [IDX_W-1:0] found_idx_ff, found_idx_in;

   // result registers
   status_type       rsp_status_ff, rsp_status_in;
   logic [POS_W-1:0] rsp_position_ff, rsp_position_in;
   logic [REM_W-1:0] rsp_removed_ff, rsp_removed_in;
   logic [OCC_W-1:0] rsp_occupancy_ff, rsp_occupancy_in;

   // record memory
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   logic [REC_W-1:0] wr_data;
   logic             rd_en;
   logic [IDX_W-1:0] rd_addr;
   logic [REC_W-1:0] rd_data;

   logic             full;
   logic             match;
   logic             issue;
   logic [CNT_W-1:0] down_addr;

   orl_ram #(
      .WIDTH (REC_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign match     = (rd_data == key_ff);
   assign issue     = (scan_ff < count_ff);
   assign down_addr = count_ff - scan_ff - CNT_W'(1);

   // status to controller
   always_comb begin
      op_type req_op;
      req_op        = op_type'(req_operation);
      sts.need_walk = (req_op == OP_SEARCH) || (req_op == OP_DELETE) ||
                      ((req_op == OP_FRONT) && !full);
      sts.walk_done = !issue && !data_vld_ff;
      sts.out_free  = !rsp_valid_ff || rsp_ready;
   end

   // next values
   always_comb begin
      count_in         = count_ff;
      data_vld_in      = data_vld_ff;
      op_in            = op_ff;
      key_in           = key_ff;
      scan_in          = scan_ff;
      data_idx_in      = data_idx_ff;
      kept_in          = kept_ff;
      removed_in       = removed_ff;
      found_in         = found_ff;
      found_idx_in     = found_idx_ff;
      rsp_status_in    = rsp_status_ff;
      rsp_position_in  = rsp_position_ff;
      rsp_removed_in   = rsp_removed_ff;
      rsp_occupancy_in = rsp_occupancy_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_ready;
      wr_en            = 1'b0;
      wr_addr          = '0;
      wr_data          = rd_data;
      rd_en            = 1'b0;
      rd_addr          = '0;

      // load a new word
      if (cmd.accept) begin
         op_in        = op_type'(req_operation);
         key_in       = {req_field_a, req_field_b, req_field_c, req_field_d};
         scan_in      = '0;
         data_vld_in  = 1'b0;
         kept_in      = '0;
         removed_in   = '0;
         found_in     = 1'b0;
         found_idx_in = '0;
      end

      // walk: issue one read, handle the entry read last cycle
      if (cmd.walk) begin
         data_vld_in = issue;
         if (issue) begin
            rd_en   = 1'b1;
            rd_addr = (op_ff == OP_FRONT) ? down_addr[IDX_W-1:0] : scan_ff[IDX_W-1:0];
            scan_in = scan_ff + CNT_W'(1);
         end
         data_idx_in = rd_addr;
         if (data_vld_ff) begin
            case (op_ff)
               OP_FRONT: begin
                  // shift toward the back
                  wr_en   = 1'b1;
                  wr_addr = data_idx_ff + IDX_W'(1);
               end
               OP_SEARCH: begin
                  if (match && !found_ff) begin
                     found_in     = 1'b1;
                     found_idx_in = data_idx_ff;
                  end
               end
               OP_DELETE: begin
                  // compact the survivors
                  if (match) begin
                     removed_in = removed_ff + CNT_W'(1);
                  end else begin
                     wr_en   = 1'b1;
                     wr_addr = kept_ff[IDX_W-1:0];
                     kept_in = kept_ff + CNT_W'(1);
                  end
               end
               default: begin
                  wr_en = 1'b0;
               end
            endcase
         end
      end

      // commit and present the result
      if (cmd.finish) begin
         rsp_valid_in    = 1'b1;
         rsp_status_in   = ST_DONE;
         rsp_position_in = '0;
         rsp_removed_in  = '0;
         case (op_ff)
            OP_FRONT, OP_BACK: begin
               if (full) begin
                  rsp_status_in = ST_FULL;
               end else begin
                  wr_en    = 1'b1;
                  wr_addr  = (op_ff == OP_FRONT) ? '0 : count_ff[IDX_W-1:0];
                  wr_data  = key_ff;
                  count_in = count_ff + CNT_W'(1);
               end
            end
            OP_SEARCH: begin
               rsp_status_in   = found_ff ? ST_DONE : ST_MISS;
               rsp_position_in = found_ff ? POS_W'(found_idx_ff) : '0;
            end
            OP_DELETE: begin
               rsp_status_in  = (removed_ff != '0) ? ST_DONE : ST_MISS;
               rsp_removed_in = REM_W'(removed_ff);
               count_in       = kept_ff;
            end
            default: begin
               rsp_status_in = ST_DONE;
            end
         endcase
         rsp_occupancy_in = OCC_W'(count_in);
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         data_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         data_vld_ff  <= data_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff            <= op_in;
      key_ff           <= key_in;
      scan_ff          <= scan_in;
      data_idx_ff      <= data_idx_in;
      kept_ff          <= kept_in;
      removed_ff       <= removed_in;
      found_ff         <= found_in;
      found_idx_ff     <= found_idx_in;
      rsp_status_ff    <= rsp_status_in;
      rsp_position_ff  <= rsp_position_in;
      rsp_removed_ff   <= rsp_removed_in;
      rsp_occupancy_ff <= rsp_occupancy_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_position  = rsp_position_ff;
   assign rsp_removed   = rsp_removed_ff;
   assign rsp_occupancy = rsp_occupancy_ff;

   // occupancy never exceeds the list size
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("occupancy above list size");

   // delete never accounts for more entries than are held
   a_delete_sum: assert property (@(posedge clock) disable iff (reset)
      cmd.walk && op_ff == OP_DELETE |-> (kept_ff + removed_ff) <= count_ff)
      else $error("delete bookkeeping overrun");

   // result is only committed into a free output register
   a_finish_free: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> (!rsp_valid_ff || rsp_ready))
      else $error("result overwritten");

   // memory writes stay inside the list
   a_wr_range: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> CNT_W'(wr_addr) < CNT_W'(DEPTH))
      else $error("write beyond list");

endmodule

>>> rtl/ordered_record_list.sv
// append and refused inserts go from accept straight to committing their result;
// front insert, search and delete first walk the list, one record read per cycle,
// shifting the records back for a front insert and compacting them for a delete
// flow: one word in progress at a time, the next is taken while a result waits;
// a new word is taken only once the last result is committed to the output register
// reset: occupancy and handshake state clear, record storage is left as is
module ordered_record_list (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [orl_pkg::OP_W-1:0]         req_operation,
   input  logic signed [orl_pkg::FLD_W-1:0] req_field_a,
   input  logic signed [orl_pkg::FLD_W-1:0] req_field_b,
   input  logic signed [orl_pkg::FLD_W-1:0] req_field_c,
   input  logic signed [orl_pkg::FLD_W-1:0] req_field_d,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [orl_pkg::ST_W-1:0]         rsp_status,
   output logic [orl_pkg::POS_W-1:0]        rsp_position,
   output logic [orl_pkg::REM_W-1:0]        rsp_removed,
   output logic [orl_pkg::OCC_W-1:0]        rsp_occupancy
);

   import orl_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // sequencing
   orl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // record storage and result
   orl_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .sts           (sts),
      .req_operation (req_operation),
      .req_field_a   (req_field_a),
      .req_field_b   (req_field_b),
      .req_field_c   (req_field_c),
      .req_field_d   (req_field_d),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_status    (rsp_status),
      .rsp_position  (rsp_position),
      .rsp_removed   (rsp_removed),
      .rsp_occupancy (rsp_occupancy)
   );

endmodule

>>> verif/tb_ordered_record_list.sv
module tb_ordered_record_list;
   import orl_pkg::*;

   localparam int QUIET_LIMIT  = 3000;
   localparam int RANDOM_WORDS = 1820;
   localparam int POOL_SIZE    = 6;
   localparam int HOLD_AT      = 700;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_AT     = 1000;

   typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} op_mix_type;

   typedef struct packed {
      logic [ST_W-1:0]  status;
      logic [POS_W-1:0] position;
      logic [REM_W-1:0] removed;
      logic [OCC_W-1:0] occupancy;
   } list_result_type;

   // mirror of the record list and queue of predicted result words
   class list_scoreboard;
      logic [REC_W-1:0] held[$];
      list_result_type  awaited[$];
      int               errors = 0;

      function int pending();
         return awaited.size();
      endfunction

      // apply one accepted word to the mirror and predict its result
      function void note_request(op_type op, logic [REC_W-1:0] rec);
         list_result_type  want;
         logic [REC_W-1:0] kept[$];
         int               gone;
         want = '0;
         gone = 0;
         case (op)
            OP_FRONT, OP_BACK: begin
               if (held.size() >= DEPTH) begin
                  want.status = ST_FULL;
               end else if (op == OP_FRONT) begin
                  held.push_front(rec);
               end else begin
                  held.push_back(rec);
               end
            end
            OP_SEARCH: begin
               want.status = ST_MISS;
               for (int i = 0; i < held.size(); i++) begin
                  if (held[i] == rec) begin
                     want.status   = ST_DONE;
                     want.position = i[POS_W-1:0];
                     break;
                  end
               end
            end
            default: begin
               foreach (held[i]) begin
                  if (held[i] == rec) gone++;
                  else kept.push_back(held[i]);
               end
               held         = kept;
               want.removed = gone[REM_W-1:0];
               want.status  = (gone == 0) ? ST_MISS : ST_DONE;
            end
         endcase
         want.occupancy = OCC_W'(held.size());
         awaited.push_back(want);
      endfunction

      function void compare_field(string name, int unsigned want, int unsigned got);
         if (want != got) begin
            $display("%0t: %s mismatch expected %0d actual %0d", $time, name, want, got);
            errors++;
         end
      endfunction

      // compare one result word with the oldest prediction
      function void check_result(logic [ST_W-1:0] status, logic [POS_W-1:0] position,
                                 logic [REM_W-1:0] removed, logic [OCC_W-1:0] occupancy);
         list_result_type want;
         if (awaited.size() == 0) begin
            $display("%0t: unexpected result expected none actual status %0d occupancy %0d",
                     $time, status, occupancy);
            errors++;
            return;
         end
         want = awaited.pop_front();
         compare_field("status", want.status, status);
         compare_field("position", want.position, position);
         compare_field("removed", want.removed, removed);
         compare_field("occupancy", want.occupancy, occupancy);
      endfunction
   endclass

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   logic [OP_W-1:0]         req_operation = OP_FRONT;
   logic signed [FLD_W-1:0] req_field_a = '0;
   logic signed [FLD_W-1:0] req_field_b = '0;
   logic signed [FLD_W-1:0] req_field_c = '0;
   logic signed [FLD_W-1:0] req_field_d = '0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic [ST_W-1:0]         rsp_status;
   logic [POS_W-1:0]        rsp_position;
   logic [REM_W-1:0]        rsp_removed;
   logic [OCC_W-1:0]        rsp_occupancy;

   list_scoreboard   book = new;
   logic [REC_W-1:0] key_pool[POOL_SIZE];
   bit               steady = 1'b0;
   int               words_checked = 0;
   int               quiet_cycles = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   ordered_record_list dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_operation (req_operation),
      .req_field_a   (req_field_a),
      .req_field_b   (req_field_b),
      .req_field_c   (req_field_c),
      .req_field_d   (req_field_d),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_status    (rsp_status),
      .rsp_position  (rsp_position),
      .rsp_removed   (rsp_removed),
      .rsp_occupancy (rsp_occupancy)
   );

   function automatic logic [REC_W-1:0] random_record();
      return {$urandom, $urandom, $urandom, $urandom};
   endfunction

   // mostly pooled keys so matches and duplicates happen, some near misses
   function automatic logic [REC_W-1:0] pick_record();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 70) return key_pool[$urandom_range(0, POOL_SIZE-1)];
      if (roll < 85)
         return key_pool[$urandom_range(0, POOL_SIZE-1)] ^ (128'b1 << $urandom_range(0, 127));
      return random_record();
   endfunction

   function automatic op_type pick_operation(op_mix_type mix);
      int roll;
      roll = $urandom_range(0, 99);
      case (mix)
         MIX_FILL:  return (roll < 40) ? OP_FRONT : (roll < 70) ? OP_BACK :
                           (roll < 90) ? OP_SEARCH : OP_DELETE;
         MIX_DRAIN: return (roll < 15) ? OP_FRONT : (roll < 30) ? OP_BACK :
                           (roll < 60) ? OP_SEARCH : OP_DELETE;
         default:   return (roll < 25) ? OP_FRONT : (roll < 50) ? OP_BACK :
                           (roll < 75) ? OP_SEARCH : OP_DELETE;
      endcase
   endfunction

   // offer one word and wait for the block to take it
   task automatic send_word(op_type op, logic [REC_W-1:0] rec);
      int gap;
      gap = steady ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_operation <= op;
      {req_field_a, req_field_b, req_field_c, req_field_d} <= rec;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      book.note_request(op, rec);
   endtask

   // stop offering until every predicted result has come back
   task automatic drain_results();
      req_valid <= 1'b0;
      while (book.pending() != 0) @(posedge clock);
   endtask

   // sender
   initial begin
      logic [REC_W-1:0] rec_a;
      logic [REC_W-1:0] rec_b;
      logic [REC_W-1:0] rec_k;
      op_mix_type       mix;
      rec_a = {32'h7fffffff, 32'h80000000, 32'h00000000, 32'hffffffff};
      rec_b = {32'h80000000, 32'h7fffffff, 32'hffffffff, 32'h00000000};
      rec_k = '0;
      mix   = MIX_EVEN;
      foreach (key_pool[i]) key_pool[i] = random_record();
      key_pool[0] = rec_a;
      key_pool[1] = {REC_W{1'b1}};
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // empty list misses
      send_word(OP_SEARCH, rec_a);
      send_word(OP_DELETE, rec_a);
      // front and back with extreme fields, duplicates at both ends
      send_word(OP_FRONT, rec_a);
      send_word(OP_BACK, rec_b);
      send_word(OP_FRONT, rec_k);
      send_word(OP_BACK, rec_k);
      send_word(OP_SEARCH, rec_k);
      send_word(OP_DELETE, rec_k);
      // last entry found and removed, near miss one bit off
      send_word(OP_SEARCH, rec_b);
      send_word(OP_SEARCH, rec_a ^ 128'b1);
      send_word(OP_DELETE, rec_b);
      send_word(OP_DELETE, rec_a);
      // fill to the limit, refuse both inserts, then remove every record
      repeat (DEPTH) send_word(OP_BACK, rec_k);
      send_word(OP_FRONT, rec_k);
      send_word(OP_BACK, rec_b);
      send_word(OP_DELETE, rec_k);

      // random words in phases that lean toward filling or draining
      for (int n = 0; n < RANDOM_WORDS; n++) begin
         if (n % 150 == 0) begin
            case ($urandom_range(0, 2))
               0:       mix = MIX_FILL;
               1:       mix = MIX_DRAIN;
               default: mix = MIX_EVEN;
            endcase
            steady = ($urandom_range(0, 4) == 0);
         end
         if (n == DRAIN_AT) drain_results();
         if ($urandom_range(0, 29) == 0)
            key_pool[$urandom_range(0, POOL_SIZE-1)] = random_record();
         send_word(pick_operation(mix), pick_record());
      end
      req_valid <= 1'b0;

      while (book.pending() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (book.errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // receiver with random stalls and one long hold-off
   initial begin
      int gap;
      wait (reset == 1'b0);
      forever begin
         gap = steady ? 0 : $urandom_range(0, 6);
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         book.check_result(rsp_status, rsp_position, rsp_removed, rsp_occupancy);
         words_checked++;
         if (words_checked == HOLD_AT) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
      end
   end

   // watchdog on cycles with no word moving on either side
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule
